### src/pff_pkg.sv
// Shared types, widths and codes for the per-feature FIR filter.
// No dependencies; every other file imports this package.
`default_nettype none

package pff_pkg;

    // Sizing of the coefficient and history stores
    localparam int MAX_ORDER    = 8;
    localparam int MAX_FEATURES = 64;

    // Fixed field widths
    localparam int FUNC_W     = 2;
    localparam int FEAT_W     = 6;
    localparam int TAP_W      = 4;
    localparam int DATA_W     = 32;
    localparam int ORDER_W    = 4;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int ACC_W      = 64;
    localparam int PROD_W     = 64;
    localparam int FRAC_BITS  = 16;

    // Derived widths
    localparam int PTR_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int AV_W    = $clog2(MAX_ORDER + 1);
    localparam int FIDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int TAP_AW  = $clog2((MAX_ORDER + 1) * MAX_FEATURES);
    localparam int HIST_AW = (MAX_ORDER * MAX_FEATURES > 1) ?
                             $clog2(MAX_ORDER * MAX_FEATURES) : 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_TAP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_BIAS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ORDER  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'd1;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_LOAD_TAP,
        OP_LOAD_BIAS
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [FEAT_W-1:0]        feature;
        logic [TAP_W-1:0]         tap;
        logic signed [DATA_W-1:0] data;
        logic                     seg;
        logic                     hist_only;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TAPS,
        ST_DRAIN
    } t_back_state;

endpackage

`default_nettype wire

### src/pff_ifs.sv
// Valid/ready channel interfaces for input and result words.
// Depends on pff_pkg for field widths.
`default_nettype none

interface pff_in_if;
    import pff_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [FEAT_W-1:0]        feature_index;
    logic [TAP_W-1:0]         tap_index;
    logic signed [DATA_W-1:0] data_value;
    logic                     segment_start;
    logic                     history_only;

    modport source (
        output valid, func, feature_index, tap_index, data_value,
               segment_start, history_only,
        input  ready
    );
    modport sink (
        input  valid, func, feature_index, tap_index, data_value,
               segment_start, history_only,
        output ready
    );
endinterface

interface pff_out_if;
    import pff_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FEAT_W-1:0]        result_feature;
    logic signed [DATA_W-1:0] filtered_value;
    logic                     saturated;

    modport source (
        output valid, result_feature, filtered_value, saturated,
        input  ready
    );
    modport sink (
        input  valid, result_feature, filtered_value, saturated,
        output ready
    );
endinterface

`default_nettype wire

### src/pff_front.sv
// Front end: configuration registers, input decode and range checks.
// Depends on pff_pkg and pff_in_if; feeds the command queue.
`default_nettype none

module pff_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [pff_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pff_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pff_in_if.sink                            i_in,
    input  wire logic                         i_full,
    output logic                              o_push,
    output pff_pkg::t_cmd                     o_cmd,
    output logic [pff_pkg::AV_W-1:0]          o_order
);
    import pff_pkg::*;

    logic [ORDER_W-1:0] r_filter_order;
    logic [COUNT_W-1:0] r_feature_count;
    logic               feat_ok;
    logic               cnt_ok;
    logic               tap_ok;
    logic               keep;
    t_op                op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_order  <= '0;
            r_feature_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_ORDER:  r_filter_order  <= i_cfg_data[ORDER_W-1:0];
                CFG_FEATURE_COUNT: r_feature_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_order = (32'(r_filter_order) > MAX_ORDER) ? AV_W'(MAX_ORDER)
                                                         : AV_W'(r_filter_order);

    assign feat_ok = 32'(i_in.feature_index) < MAX_FEATURES;
    assign cnt_ok  = COUNT_W'(i_in.feature_index) < r_feature_count;
    assign tap_ok  = 32'(i_in.tap_index) <= MAX_ORDER;

    // Words that change nothing are dropped here and never reach the queue
    always_comb begin
        keep = 1'b0;
        op   = OP_SAMPLE;
        unique case (i_in.func)
            FUNC_SAMPLE: begin
                op   = OP_SAMPLE;
                keep = feat_ok && cnt_ok;
            end
            FUNC_LOAD_TAP: begin
                op   = OP_LOAD_TAP;
                keep = feat_ok && tap_ok;
            end
            FUNC_LOAD_BIAS: begin
                op   = OP_LOAD_BIAS;
                keep = feat_ok;
            end
            default: keep = 1'b0;
        endcase
    end

    assign i_in.ready = ~i_full;
    assign o_push     = i_in.valid && !i_full && keep;

    always_comb begin
        o_cmd.op        = op;
        o_cmd.feature   = i_in.feature_index;
        o_cmd.tap       = i_in.tap_index;
        o_cmd.data      = i_in.data_value;
        o_cmd.seg       = i_in.segment_start;
        o_cmd.hist_only = i_in.history_only;
    end

endmodule

`default_nettype wire

### src/pff_queue.sv
// Short command FIFO that decouples decode from the MAC back end.
// Depends on pff_pkg for the command type and depth.
`default_nettype none

module pff_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pff_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output pff_pkg::t_cmd       o_cmd
);
    import pff_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/pff_back.sv
// Back end: tap/bias/history memories, per-feature delay line state and
// the shared multiply-accumulate sequencer. Depends on pff_pkg, pff_out_if.
`default_nettype none

module pff_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire pff_pkg::t_cmd         i_q_cmd,
    output logic                       o_q_pop,
    input  wire logic [pff_pkg::AV_W-1:0] i_order,
    pff_out_if.source                  o_out
);
    import pff_pkg::*;

    typedef struct packed {
        logic [PTR_W-1:0] ptr;
        logic [AV_W-1:0]  avail;
    } t_meta;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    // Memories
    logic signed [DATA_W-1:0] r_tap_mem  [(MAX_ORDER + 1) * MAX_FEATURES];
    logic signed [DATA_W-1:0] r_bias_mem [MAX_FEATURES];
    logic signed [DATA_W-1:0] r_hist_mem [MAX_ORDER * MAX_FEATURES];
    t_meta                    r_meta_mem [MAX_FEATURES];
    logic [MAX_FEATURES-1:0]  r_meta_vld;

    logic signed [DATA_W-1:0] r_tap_rd;
    logic signed [DATA_W-1:0] r_bias_rd;
    logic signed [DATA_W-1:0] r_hist_rd;
    t_meta                    r_meta_rd;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;

    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  r_slot;
    logic [AV_W-1:0]   r_avail;
    logic [AV_W-1:0]   r_n;
    logic [AV_W-1:0]   r_h;
    logic [TAP_AW-1:0] r_taddr;

    logic                     r_rd_v;
    logic                     r_rd_cur;
    logic                     r_prod_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_out_valid;
    logic [FEAT_W-1:0]        r_out_feature;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_sat;

    logic              tap_we;
    logic              bias_we;
    logic              take_sample;
    logic              issue;
    logic              finish;
    logic              out_free;
    logic [TAP_AW-1:0] tap_raddr;
    logic [TAP_AW-1:0] tap_waddr;
    logic [FIDX_W-1:0] q_fidx;
    logic [FIDX_W-1:0] c_fidx;
    logic [AV_W-1:0]   head_avail;
    logic [AV_W-1:0]   head_n;
    logic [PTR_W-1:0]  head_ptr;
    logic [HIST_AW-1:0] hist_raddr;
    logic [HIST_AW-1:0] hist_waddr;
    logic signed [DATA_W-1:0] mul_a;
    logic              sat_hi;
    logic              sat_lo;
    t_meta             meta_next;

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] s);
        return (s == '0) ? PTR_W'(MAX_ORDER - 1) : s - 1'b1;
    endfunction

    assign q_fidx    = FIDX_W'(i_q_cmd.feature);
    assign c_fidx    = FIDX_W'(r_cmd.feature);
    assign out_free  = !r_out_valid || o_out.ready;
    assign tap_waddr = TAP_AW'(32'(i_q_cmd.tap) * MAX_FEATURES + 32'(i_q_cmd.feature));
    assign hist_raddr = HIST_AW'(32'(r_cmd.feature) * MAX_ORDER + 32'(r_slot));
    assign hist_waddr = HIST_AW'(32'(r_cmd.feature) * MAX_ORDER + 32'(r_ptr));

    // Delay-line state as seen by the sample now in HEAD
    assign head_ptr   = r_meta_vld[c_fidx] ? r_meta_rd.ptr : '0;
    assign head_avail = (r_cmd.seg || !r_meta_vld[c_fidx]) ? '0 : r_meta_rd.avail;
    assign head_n     = r_cmd.hist_only ? '0 :
                        (head_avail < i_order) ? head_avail : i_order;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        tap_we      = 1'b0;
        bias_we     = 1'b0;
        take_sample = 1'b0;
        issue       = 1'b0;
        finish      = 1'b0;
        tap_raddr   = r_taddr;
        unique case (r_state)
            ST_IDLE: begin
                tap_raddr = TAP_AW'(i_q_cmd.feature);
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.op)
                        OP_LOAD_TAP:  tap_we  = 1'b1;
                        OP_LOAD_BIAS: bias_we = 1'b1;
                        OP_SAMPLE: begin
                            take_sample = 1'b1;
                            n_state     = ST_HEAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_HEAD: begin
                n_state = (head_n == '0) ? ST_DRAIN : ST_TAPS;
            end
            ST_TAPS: begin
                issue = 1'b1;
                if (r_h == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_v && !r_prod_v && (r_cmd.hist_only || out_free)) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (tap_we) begin
            r_tap_mem[tap_waddr] <= i_q_cmd.data;
        end
        r_tap_rd <= r_tap_mem[tap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bias_we) begin
            r_bias_mem[q_fidx] <= i_q_cmd.data;
        end
        r_bias_rd <= r_bias_mem[q_fidx];
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_hist_mem[hist_waddr] <= r_cmd.data;
        end
        r_hist_rd <= r_hist_mem[hist_raddr];
    end

    always_comb begin
        meta_next.ptr   = (r_ptr == PTR_W'(MAX_ORDER - 1)) ? '0 : r_ptr + 1'b1;
        meta_next.avail = (r_avail < AV_W'(MAX_ORDER)) ? r_avail + 1'b1
                                                        : AV_W'(MAX_ORDER);
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_meta_mem[c_fidx] <= meta_next;
        end
        r_meta_rd <= r_meta_mem[q_fidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_vld <= '0;
        end else if (finish) begin
            r_meta_vld[c_fidx] <= 1'b1;
        end
    end

    // Command and tap walk
    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == ST_HEAD) begin
            r_ptr   <= head_ptr;
            r_avail <= head_avail;
            r_n     <= head_n;
            r_h     <= AV_W'(1);
            r_slot  <= slot_dec(head_ptr);
            r_taddr <= TAP_AW'(32'(r_cmd.feature) + MAX_FEATURES);
        end else if (issue) begin
            r_h     <= r_h + 1'b1;
            r_slot  <= slot_dec(r_slot);
            r_taddr <= r_taddr + TAP_AW'(MAX_FEATURES);
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_rd_cur <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= take_sample || issue;
            r_rd_cur <= take_sample;
            r_prod_v <= r_rd_v;
        end
    end

    // Tap 0 multiplies the present sample, later taps the delay line
    assign mul_a = r_rd_cur ? r_cmd.data : r_hist_rd;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(r_tap_rd);
        if (r_state == ST_HEAD) begin
            r_acc <= ACC_W'(r_bias_rd);
        end else if (r_prod_v) begin
            r_acc <= r_acc + (r_prod >>> FRAC_BITS);
        end
    end

    // Output register
    assign sat_hi = r_acc > SAT_MAX;
    assign sat_lo = r_acc < SAT_MIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish && !r_cmd.hist_only) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish && !r_cmd.hist_only) begin
            r_out_feature <= r_cmd.feature;
            r_out_sat     <= sat_hi || sat_lo;
            r_out_value   <= sat_hi ? SAT_MAX[DATA_W-1:0] :
                             sat_lo ? SAT_MIN[DATA_W-1:0] : r_acc[DATA_W-1:0];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_feature = r_out_feature;
    assign o_out.filtered_value = r_out_value;
    assign o_out.saturated      = r_out_sat;

`ifndef NO_ASSERTIONS
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_rd_v && !r_prod_v))
        else $error("MAC pipeline busy while idle");

    a_taps_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAPS) |-> (r_h <= r_n && r_n != '0 && !r_cmd.hist_only))
        else $error("tap walk out of range");

    a_head_then_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HEAD) |=> r_prod_v)
        else $error("tap 0 product missing after head");

    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DRAIN))
        else $error("result word loaded outside drain");
`endif

endmodule

`default_nettype wire

### src/per_feature_fir_filter.sv
// Per-feature FIR filter with bias. A load word (tap or bias) is written to
// its memory without the back end leaving idle. A sample word uses n past
// samples (n is the smaller of the samples seen in its segment and the filter
// order, at most 8); a history-only word uses none. The single
// multiply-accumulate walks one tap per cycle through the tap and history
// memories behind a two-stage read/multiply pipeline. A four-word command
// queue sits between decode and the MAC, so input words are taken while a
// sample is in work. A finished result waits in an output register; the back
// end holds the next result in drain until the waiting one is taken. Tap, bias
// and history memories are undefined until loaded; the per-feature pointer
// and sample count come out of reset cleared.
`default_nettype none

module per_feature_fir_filter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pff_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pff_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pff_in_if.sink                              i_in,
    pff_out_if.source                           o_out
);
    import pff_pkg::*;

    logic            push;
    logic            full;
    logic            q_valid;
    logic            q_pop;
    t_cmd            push_cmd;
    t_cmd            q_cmd;
    logic [AV_W-1:0] order;

    pff_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_order    (order)
    );

    pff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    pff_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .i_order   (order),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
